### rtl/batch_min_max_mean_range_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the batch statistics core
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BATCH_MIN_MAX_MEAN_RANGE_CORE_MACROS_SVH
`define BATCH_MIN_MAX_MEAN_RANGE_CORE_MACROS_SVH

// same-cycle implication
`define BMMMR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMMMR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bmmmr_pkg.sv
// ----------------------------------------------------------------------------
// bmmmr_pkg
// Shared types and constants of the batch statistics core.
// ----------------------------------------------------------------------------
`default_nettype none

package bmmmr_pkg;

  localparam int DATA_W            = 32;  // width of every result field
  localparam int SUM_W             = 64;  // accumulator width
  localparam int STEP_W            = $clog2(SUM_W);
  localparam int SAMPLE_WIDTH_DEF  = 32;
  localparam int COUNT_WIDTH_DEF   = 32;

  typedef enum logic [2:0] {
    ST_ACCUM  = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic acc_en;    // take a sample into the accumulators
    logic div_step;  // one restoring-divide step
    logic out_load;  // load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_last;  // divider is on its final step
  } sts_t;

endpackage

`default_nettype wire

### rtl/bmmmr_ctrl.sv
// ----------------------------------------------------------------------------
// bmmmr_ctrl
// Sequencer: accumulate, divide, hand result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmmmr_ctrl
  import bmmmr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic last_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  assign in_ready_o = (state_q == ST_ACCUM);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.acc_en   = in_acc;
    case (state_q)
      ST_ACCUM: begin
        if (in_acc && last_i) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### rtl/bmmmr_dp.sv
// ----------------------------------------------------------------------------
// bmmmr_dp
// Accumulators, staging registers, bit-serial divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmmmr_dp
  import bmmmr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DATA_W-1:0] sample_i,
  input  logic              last_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [DATA_W-1:0] mean_o,
  output logic [DATA_W-1:0] maximum_o,
  output logic [DATA_W-1:0] minimum_o,
  output logic [DATA_W-1:0] spread_o,
  output logic [DATA_W-1:0] sample_count_o
);

  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

  // running state
  logic signed [SAMPLE_WIDTH-1:0] max_q, min_q;
  logic        [SUM_W-1:0]        sum_q;
  logic        [COUNT_WIDTH-1:0]  cnt_q;

  // updated values with the current sample folded in
  logic signed [SAMPLE_WIDTH-1:0] smp;
  logic signed [DATA_W-1:0]       smp_ext;
  logic signed [SAMPLE_WIDTH-1:0] max_upd, min_upd;
  logic        [SUM_W-1:0]        sum_upd, sum_abs;
  logic        [COUNT_WIDTH-1:0]  cnt_upd;

  // staged batch result and divider
  logic signed [SAMPLE_WIDTH-1:0] st_max_q, st_min_q;
  logic        [COUNT_WIDTH-1:0]  div_q;     // divisor = batch count
  logic        [COUNT_WIDTH-1:0]  rem_q, rem_d;
  logic        [SUM_W-1:0]        quo_q, quo_d;
  logic                           neg_q;
  logic        [STEP_W-1:0]       step_q;
  logic        [COUNT_WIDTH+1:0]  diff;
  logic                           ge;

  logic        [DATA_W-1:0]       mean_res, max_ext, min_ext;

  assign smp     = signed'(sample_i[SAMPLE_WIDTH-1:0]);
  assign smp_ext = DATA_W'(smp);
  assign max_upd = (smp > max_q) ? smp : max_q;
  assign min_upd = (smp < min_q) ? smp : min_q;
  assign sum_upd = sum_q + SUM_W'(smp_ext);
  assign cnt_upd = (&cnt_q) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
  assign sum_abs = sum_upd[SUM_W-1] ? (SUM_W'(0) - sum_upd) : sum_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= SMP_MIN;
      min_q <= SMP_MAX;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.acc_en) begin
      if (last_i) begin
        max_q <= SMP_MIN;
        min_q <= SMP_MAX;
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        max_q <= max_upd;
        min_q <= min_upd;
        sum_q <= sum_upd;
        cnt_q <= cnt_upd;
      end
    end
  end

  // restoring divide of |sum| by count, one quotient bit per step
  assign diff  = {1'b0, rem_q, quo_q[SUM_W-1]} - {2'b00, div_q};
  assign ge    = !diff[COUNT_WIDTH+1];
  assign rem_d = ge ? diff[COUNT_WIDTH-1:0] : {rem_q[COUNT_WIDTH-2:0], quo_q[SUM_W-1]};
  assign quo_d = {quo_q[SUM_W-2:0], ge};

  assign sts_o.div_last = (step_q == STEP_W'(SUM_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.acc_en && last_i) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en && last_i) begin
      st_max_q <= max_upd;
      st_min_q <= min_upd;
      div_q    <= cnt_upd;
      rem_q    <= '0;
      quo_q    <= sum_abs;
      neg_q    <= sum_upd[SUM_W-1];
    end else if (cmd_i.div_step) begin
      rem_q    <= rem_d;
      quo_q    <= quo_d;
    end
  end

  assign mean_res = neg_q ? (~quo_q[DATA_W-1:0] + DATA_W'(1)) : quo_q[DATA_W-1:0];
  assign max_ext  = DATA_W'(st_max_q);
  assign min_ext  = DATA_W'(st_min_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      mean_o         <= mean_res;
      maximum_o      <= max_ext;
      minimum_o      <= min_ext;
      spread_o       <= max_ext - min_ext;
      sample_count_o <= DATA_W'(div_q);
    end
  end

endmodule

`default_nettype wire

### rtl/batch_min_max_mean_range_core.sv
// ----------------------------------------------------------------------------
// batch_min_max_mean_range_core
// Per-batch min, max, truncated mean, range and count of signed samples.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | word
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o | sample_i, last_i
//  out     | out_valid_o/out_ready_i | mean_o, maximum_o, minimum_o, spread_o,
//          |                         | sample_count_o
//
//  Flow: a sample without last is taken every cycle. A last sample closes
//    the batch and starts a restoring divide of the 64-bit sum by the count,
//    one quotient bit per cycle: in_ready_o stays low through the divide and
//    the finish state, where the result register is loaded once it is free.
//  Stalls: the result register holds a finished batch while the next one
//    accumulates; a new result waits in the finish state until it is free.
//  Reset: async, active low; clears the accumulators to their idle values,
//    the sequencer to accumulate and the output valid.
//
// ----------------------------------------------------------------------------
`default_nettype none

`include "batch_min_max_mean_range_core_macros.svh"

module batch_min_max_mean_range_core
  import bmmmr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,  // low bits of sample_i used
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF    // saturating counter width
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] sample_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] mean_o,
  output logic [DATA_W-1:0] maximum_o,
  output logic [DATA_W-1:0] minimum_o,
  output logic [DATA_W-1:0] spread_o,
  output logic [DATA_W-1:0] sample_count_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the handshakes and the output valid
  bmmmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // accumulators, divider and result register
  bmmmr_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .last_i         (last_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mean_o         (mean_o),
    .maximum_o      (maximum_o),
    .minimum_o      (minimum_o),
    .spread_o       (spread_o),
    .sample_count_o (sample_count_o)
  );

  // closing word must stall the input for the divide
  `BMMMR_ASSERT_NXT(a_close_stalls, in_valid_i && in_ready_o && last_i, !in_ready_o, "input ready during divide")
  // range field agrees with max and min
  `BMMMR_ASSERT_IMP(a_spread, out_valid_o, spread_o == maximum_o - minimum_o, "spread mismatch")
  // a batch never reports zero samples
  `BMMMR_ASSERT_IMP(a_count_nz, out_valid_o, sample_count_o != '0, "empty batch reported")
  // maximum never below minimum
  `BMMMR_ASSERT_IMP(a_order, out_valid_o, $signed(maximum_o) >= $signed(minimum_o), "max below min")

endmodule

`default_nettype wire
